// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// boolean expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== design/olfb_pkg.sv =====
// ---------------------------------------------------------------------------
// olfb_pkg
// Widths, codes, control word types and the microcode table of the list.
// ---------------------------------------------------------------------------
package olfb_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int VAL_W   = 32;
	localparam int ELEM_W  = 31;
	localparam int STAT_W  = 3;
	localparam int TDATA_W = ((ELEM_W + 7) / 8) * 8;
	localparam int TUSER_W = STAT_W + 1;

	// result status codes
	localparam logic [STAT_W-1:0] STS_OK       = 3'd0;
	localparam logic [STAT_W-1:0] STS_NOTFOUND = 3'd1;
	localparam logic [STAT_W-1:0] STS_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] STS_ENDED    = 3'd3;
	localparam logic [STAT_W-1:0] STS_IGNORED  = 3'd4;

	// microprogram steps
	localparam int NUM_STEPS = 26;
	localparam int STEP_W    = $clog2(NUM_STEPS);
	localparam logic [STEP_W-1:0] U_FETCH  = 5'd0;
	localparam logic [STEP_W-1:0] U_D_END  = 5'd1;
	localparam logic [STEP_W-1:0] U_D_ZERO = 5'd2;
	localparam logic [STEP_W-1:0] U_D_NEG  = 5'd3;
	localparam logic [STEP_W-1:0] U_D_FULL = 5'd4;
	localparam logic [STEP_W-1:0] U_D_EVEN = 5'd5;
	localparam logic [STEP_W-1:0] U_PB     = 5'd6;
	localparam logic [STEP_W-1:0] U_PF0    = 5'd7;
	localparam logic [STEP_W-1:0] U_PF1    = 5'd8;
	localparam logic [STEP_W-1:0] U_PF2    = 5'd9;
	localparam logic [STEP_W-1:0] U_PF3    = 5'd10;
	localparam logic [STEP_W-1:0] U_FULLST = 5'd11;
	localparam logic [STEP_W-1:0] U_ENDRUN = 5'd12;
	localparam logic [STEP_W-1:0] U_IGN    = 5'd13;
	localparam logic [STEP_W-1:0] U_R0     = 5'd14;
	localparam logic [STEP_W-1:0] U_R1     = 5'd15;
	localparam logic [STEP_W-1:0] U_R2     = 5'd16;
	localparam logic [STEP_W-1:0] U_R3     = 5'd17;
	localparam logic [STEP_W-1:0] U_RS1    = 5'd18;
	localparam logic [STEP_W-1:0] U_RS2    = 5'd19;
	localparam logic [STEP_W-1:0] U_RS3    = 5'd20;
	localparam logic [STEP_W-1:0] U_EM0    = 5'd21;
	localparam logic [STEP_W-1:0] U_EM1    = 5'd22;
	localparam logic [STEP_W-1:0] U_EM2    = 5'd23;
	localparam logic [STEP_W-1:0] U_EM3    = 5'd24;
	localparam logic [STEP_W-1:0] U_SINGLE = 5'd25;

	// jump conditions
	localparam logic [3:0] C_ALWAYS   = 4'd0;
	localparam logic [3:0] C_IN_VALID = 4'd1;
	localparam logic [3:0] C_ENDED    = 4'd2;
	localparam logic [3:0] C_ZERO     = 4'd3;
	localparam logic [3:0] C_NEG      = 4'd4;
	localparam logic [3:0] C_FULL     = 4'd5;
	localparam logic [3:0] C_EVEN     = 4'd6;
	localparam logic [3:0] C_IDX_ZERO = 4'd7;
	localparam logic [3:0] C_IDX_END  = 4'd8;
	localparam logic [3:0] C_MATCH    = 4'd9;
	localparam logic [3:0] C_LAST     = 4'd10;
	localparam logic [3:0] C_EMPTY    = 4'd11;

	// index register operations
	localparam logic [2:0] IX_HOLD = 3'd0;
	localparam logic [2:0] IX_ZERO = 3'd1;
	localparam logic [2:0] IX_CNT  = 3'd2;
	localparam logic [2:0] IX_INC  = 3'd3;
	localparam logic [2:0] IX_DEC  = 3'd4;

	// read address select
	localparam logic [1:0] RA_IDX = 2'd0;
	localparam logic [1:0] RA_M1  = 2'd1;
	localparam logic [1:0] RA_P1  = 2'd2;

	// count operations
	localparam logic [1:0] CN_HOLD = 2'd0;
	localparam logic [1:0] CN_INC  = 2'd1;
	localparam logic [1:0] CN_DEC  = 2'd2;

	// emit kinds
	localparam logic [1:0] EM_NONE   = 2'd0;
	localparam logic [1:0] EM_LIST   = 2'd1;
	localparam logic [1:0] EM_SINGLE = 2'd2;

	typedef struct packed {
		logic                wait_out;
		logic                accept;
		logic [2:0]          idx_op;
		logic [1:0]          ra_sel;
		logic                wr_en;
		logic                wa_cnt;
		logic                wd_val;
		logic [1:0]          cnt_op;
		logic                st_set;
		logic [STAT_W-1:0]   st_val;
		logic                set_end;
		logic [1:0]          emit;
	} dp_ctrl_t;

	typedef struct packed {
		logic [3:0]          cond;
		logic                inv;
		logic [STEP_W-1:0]   target;
		dp_ctrl_t            dp;
	} uop_t;

	typedef struct packed {
		logic in_valid;
		logic ended;
		logic zero;
		logic neg;
		logic full;
		logic even;
		logic idx_zero;
		logic idx_end;
		logic match;
		logic last;
		logic empty;
		logic out_busy;
	} dp_flags_t;

	// microcode table: one control word per step
	function automatic uop_t ucode(input logic [STEP_W-1:0] step);
		uop_t u;
		u = '0;
		u.inv = 1'b1;   // default: no jump, fall through
		case (step)
			U_FETCH: begin
				u.dp.accept = 1'b1;
				u.cond = C_IN_VALID; u.inv = 1'b1; u.target = U_FETCH;
			end
			U_D_END: begin
				u.cond = C_ENDED; u.inv = 1'b0; u.target = U_IGN;
			end
			U_D_ZERO: begin
				u.cond = C_ZERO; u.inv = 1'b0; u.target = U_ENDRUN;
			end
			U_D_NEG: begin
				u.cond = C_NEG; u.inv = 1'b0; u.target = U_R0;
			end
			U_D_FULL: begin
				u.cond = C_FULL; u.inv = 1'b0; u.target = U_FULLST;
			end
			U_D_EVEN: begin
				u.cond = C_EVEN; u.inv = 1'b0; u.target = U_PF0;
			end
			U_PB: begin
				u.dp.wr_en = 1'b1; u.dp.wa_cnt = 1'b1; u.dp.wd_val = 1'b1;
				u.dp.cnt_op = CN_INC;
				u.dp.st_set = 1'b1; u.dp.st_val = STS_OK;
				u.cond = C_ALWAYS; u.inv = 1'b0; u.target = U_EM0;
			end
			U_PF0: begin
				u.dp.idx_op = IX_CNT;
			end
			U_PF1: begin
				u.dp.ra_sel = RA_M1;
				u.cond = C_IDX_ZERO; u.inv = 1'b0; u.target = U_PF3;
			end
			U_PF2: begin
				u.dp.wr_en = 1'b1;
				u.dp.idx_op = IX_DEC;
				u.cond = C_ALWAYS; u.inv = 1'b0; u.target = U_PF1;
			end
			U_PF3: begin
				u.dp.wr_en = 1'b1; u.dp.wd_val = 1'b1;
				u.dp.cnt_op = CN_INC;
				u.dp.st_set = 1'b1; u.dp.st_val = STS_OK;
				u.cond = C_ALWAYS; u.inv = 1'b0; u.target = U_EM0;
			end
			U_FULLST: begin
				u.dp.st_set = 1'b1; u.dp.st_val = STS_FULL;
				u.cond = C_ALWAYS; u.inv = 1'b0; u.target = U_EM0;
			end
			U_ENDRUN: begin
				u.dp.set_end = 1'b1;
				u.dp.st_set = 1'b1; u.dp.st_val = STS_ENDED;
				u.cond = C_ALWAYS; u.inv = 1'b0; u.target = U_EM0;
			end
			U_IGN: begin
				u.dp.st_set = 1'b1; u.dp.st_val = STS_IGNORED;
				u.cond = C_ALWAYS; u.inv = 1'b0; u.target = U_SINGLE;
			end
			U_R0: begin
				u.dp.idx_op = IX_ZERO;
				u.dp.st_set = 1'b1; u.dp.st_val = STS_NOTFOUND;
			end
			U_R1: begin
				u.dp.ra_sel = RA_IDX;
				u.cond = C_IDX_END; u.inv = 1'b0; u.target = U_EM0;
			end
			U_R2: begin
				u.cond = C_MATCH; u.inv = 1'b0; u.target = U_RS1;
			end
			U_R3: begin
				u.dp.idx_op = IX_INC;
				u.cond = C_ALWAYS; u.inv = 1'b0; u.target = U_R1;
			end
			U_RS1: begin
				u.dp.ra_sel = RA_P1;
				u.dp.st_set = 1'b1; u.dp.st_val = STS_OK;
				u.cond = C_LAST; u.inv = 1'b0; u.target = U_RS3;
			end
			U_RS2: begin
				u.dp.wr_en = 1'b1;
				u.dp.idx_op = IX_INC;
				u.cond = C_ALWAYS; u.inv = 1'b0; u.target = U_RS1;
			end
			U_RS3: begin
				u.dp.cnt_op = CN_DEC;
				u.cond = C_ALWAYS; u.inv = 1'b0; u.target = U_EM0;
			end
			U_EM0: begin
				u.dp.idx_op = IX_ZERO;
				u.cond = C_EMPTY; u.inv = 1'b0; u.target = U_SINGLE;
			end
			U_EM1: begin
				u.dp.ra_sel = RA_IDX;
			end
			U_EM2: begin
				u.dp.wait_out = 1'b1;
				u.dp.emit = EM_LIST;
				u.dp.idx_op = IX_INC;
				u.dp.ra_sel = RA_P1;
				u.cond = C_LAST; u.inv = 1'b1; u.target = U_EM2;
			end
			U_EM3: begin
				u.cond = C_ALWAYS; u.inv = 1'b0; u.target = U_FETCH;
			end
			U_SINGLE: begin
				u.dp.wait_out = 1'b1;
				u.dp.emit = EM_SINGLE;
				u.cond = C_ALWAYS; u.inv = 1'b0; u.target = U_FETCH;
			end
			default: begin
				u.cond = C_ALWAYS; u.inv = 1'b0; u.target = U_FETCH;
			end
		endcase
		return u;
	endfunction

endpackage

// ===== design/ordered_list_front_back_remove.sv =====
// ---------------------------------------------------------------------------
// ordered_list_front_back_remove
// Ordered list with front insert, back insert and remove-first-match.
// ---------------------------------------------------------------------------
// The block holds an ordered list of up to olfb_pkg::DEPTH positive 31-bit
// values, empty after reset. Each input word is a signed 32-bit command:
// a negative value removes the first entry equal to its magnitude, a positive
// even value goes to the front, a positive odd value goes to the back, and
// zero ends the run. After every input the whole list is sent front to back,
// one output word per entry, tlast on the final one; an empty list (and every
// input after the end of the run) gives one word with element zero and tlast.
// tuser carries the list-empty flag and the status (ok, not found, full insert
// dropped, ended, ignored). One input word is taken at a time: s_tready is
// high only while the block waits for a command. Control is a microprogram
// stepping once per cycle, save while an output word cannot be placed, over
// a list memory with one write port and a registered read port. An input is
// fetched and then dispatched on its value. A front insert moves every entry
// one place back before it writes the value at the front; a removal scans
// from the front for the first match and then moves each later entry one
// place forward. Finally the list is sent entry by entry, or a single word
// is sent, and any output stall holds the sequence.
// The list memory needs no clearing after reset.
// ---------------------------------------------------------------------------
module ordered_list_front_back_remove (
	input  logic                          clk,
	input  logic                          arst_n,
	// command input
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [olfb_pkg::VAL_W-1:0]    s_tdata,   // [31:0] value (signed)
	// list output
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [olfb_pkg::TDATA_W-1:0]  m_tdata,   // [30:0] element, [31] zero
	output logic                          m_tlast,   // is_last
	output logic [olfb_pkg::TUSER_W-1:0]  m_tuser    // [0] list_empty, [3:1] status
);

	olfb_pkg::dp_ctrl_t  ctl;
	olfb_pkg::dp_flags_t flags;
	logic                stall;

	// accept a command word only in the fetch step of the microprogram
	assign s_tready = ctl.accept;

	// sequencer: step counter, microcode table, jump on datapath flags
	olfb_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl),
		.stall  (stall)
	);

	// datapath: list memory, count/index registers and output register
	olfb_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.stall    (stall),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.m_tready (m_tready),
		.flags    (flags),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== design/olfb_seq.sv =====
// ---------------------------------------------------------------------------
// olfb_seq
// Step counter, microcode lookup and conditional jump logic.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module olfb_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  olfb_pkg::dp_flags_t  flags,
	output olfb_pkg::dp_ctrl_t   ctl,
	output logic                 stall
);

	logic [olfb_pkg::STEP_W-1:0] step_q;
	logic [olfb_pkg::STEP_W-1:0] step_nxt;
	olfb_pkg::uop_t              u;
	logic                        cond_raw;
	logic                        take;

	assign u     = olfb_pkg::ucode(step_q);
	assign ctl   = u.dp;
	// hold the step while its output word cannot be placed
	assign stall = u.dp.wait_out && flags.out_busy;

	always_comb begin
		case (u.cond)
			olfb_pkg::C_ALWAYS:   cond_raw = 1'b1;
			olfb_pkg::C_IN_VALID: cond_raw = flags.in_valid;
			olfb_pkg::C_ENDED:    cond_raw = flags.ended;
			olfb_pkg::C_ZERO:     cond_raw = flags.zero;
			olfb_pkg::C_NEG:      cond_raw = flags.neg;
			olfb_pkg::C_FULL:     cond_raw = flags.full;
			olfb_pkg::C_EVEN:     cond_raw = flags.even;
			olfb_pkg::C_IDX_ZERO: cond_raw = flags.idx_zero;
			olfb_pkg::C_IDX_END:  cond_raw = flags.idx_end;
			olfb_pkg::C_MATCH:    cond_raw = flags.match;
			olfb_pkg::C_LAST:     cond_raw = flags.last;
			olfb_pkg::C_EMPTY:    cond_raw = flags.empty;
			default:              cond_raw = 1'b0;
		endcase
	end

	assign take = cond_raw ^ u.inv;

	always_comb begin
		if (stall) begin
			step_nxt = step_q;
		end else if (take) begin
			step_nxt = u.target;
		end else begin
			step_nxt = step_q + olfb_pkg::STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= olfb_pkg::U_FETCH;
		end else begin
			step_q <= step_nxt;
		end
	end

	`ASSERT_ALWAYS(a_step_range, clk, arst_n, step_q < olfb_pkg::STEP_W'(olfb_pkg::NUM_STEPS))
	`ASSERT_ALWAYS(a_fetch_dispatch, clk, arst_n, (u.dp.accept && flags.in_valid) |=> (step_q == olfb_pkg::U_D_END))

endmodule

// ===== design/olfb_dp.sv =====
// ---------------------------------------------------------------------------
// olfb_dp
// List memory, count, index and status registers, and the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module olfb_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  olfb_pkg::dp_ctrl_t            ctl,
	input  logic                          stall,
	input  logic                          s_tvalid,
	input  logic [olfb_pkg::VAL_W-1:0]    s_tdata,
	input  logic                          m_tready,
	output olfb_pkg::dp_flags_t           flags,
	output logic                          m_tvalid,
	output logic [olfb_pkg::TDATA_W-1:0]  m_tdata,
	output logic                          m_tlast,
	output logic [olfb_pkg::TUSER_W-1:0]  m_tuser
);

	logic                          go;
	logic [olfb_pkg::VAL_W-1:0]    val_q;
	logic [olfb_pkg::VAL_W-1:0]    mag;
	logic [olfb_pkg::CNT_W-1:0]    cnt_q;
	logic [olfb_pkg::CNT_W-1:0]    idx_q;
	logic [olfb_pkg::CNT_W-1:0]    idx_p1;
	logic [olfb_pkg::CNT_W-1:0]    idx_m1;
	logic                          ended_q;
	logic [olfb_pkg::STAT_W-1:0]   status_q;
	logic [olfb_pkg::ELEM_W-1:0]   mem_q [olfb_pkg::DEPTH];
	logic [olfb_pkg::ELEM_W-1:0]   rd_q;
	logic [olfb_pkg::IDX_W-1:0]    raddr;
	logic [olfb_pkg::IDX_W-1:0]    waddr;
	logic [olfb_pkg::ELEM_W-1:0]   wdata;
	logic                          out_valid_q;
	logic [olfb_pkg::ELEM_W-1:0]   elem_q;
	logic                          last_q;
	logic                          empty_q;
	logic [olfb_pkg::STAT_W-1:0]   ostat_q;

	assign go     = !stall;
	assign idx_p1 = idx_q + olfb_pkg::CNT_W'(1);
	assign idx_m1 = idx_q - olfb_pkg::CNT_W'(1);
	assign mag    = olfb_pkg::VAL_W'(0) - val_q;

	always_comb begin
		flags.in_valid = s_tvalid;
		flags.ended    = ended_q;
		flags.zero     = (val_q == '0);
		flags.neg      = val_q[olfb_pkg::VAL_W-1];
		flags.full     = (cnt_q == olfb_pkg::CNT_W'(olfb_pkg::DEPTH));
		flags.even     = !val_q[0];
		flags.idx_zero = (idx_q == '0);
		flags.idx_end  = (idx_q == cnt_q);
		flags.match    = ({1'b0, rd_q} == mag);
		flags.last     = (idx_p1 == cnt_q);
		flags.empty    = (cnt_q == '0);
		flags.out_busy = out_valid_q && !m_tready;
	end

	always_comb begin
		case (ctl.ra_sel)
			olfb_pkg::RA_IDX: raddr = idx_q[olfb_pkg::IDX_W-1:0];
			olfb_pkg::RA_M1:  raddr = idx_m1[olfb_pkg::IDX_W-1:0];
			olfb_pkg::RA_P1:  raddr = idx_p1[olfb_pkg::IDX_W-1:0];
			default:          raddr = idx_q[olfb_pkg::IDX_W-1:0];
		endcase
	end

	assign waddr = ctl.wa_cnt ? cnt_q[olfb_pkg::IDX_W-1:0] : idx_q[olfb_pkg::IDX_W-1:0];
	assign wdata = ctl.wd_val ? val_q[olfb_pkg::ELEM_W-1:0] : rd_q;

	// list memory: one write and one registered read per cycle, held while stalled
	always_ff @(posedge clk) begin
		if (go) begin
			if (ctl.wr_en) begin
				mem_q[waddr] <= wdata;
			end
			rd_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept && s_tvalid) begin
			val_q <= s_tdata;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			case (ctl.idx_op)
				olfb_pkg::IX_HOLD: idx_q <= idx_q;
				olfb_pkg::IX_ZERO: idx_q <= '0;
				olfb_pkg::IX_CNT:  idx_q <= cnt_q;
				olfb_pkg::IX_INC:  idx_q <= idx_p1;
				olfb_pkg::IX_DEC:  idx_q <= idx_m1;
				default:           idx_q <= idx_q;
			endcase
			if (ctl.st_set) begin
				status_q <= ctl.st_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ended_q <= 1'b0;
		end else if (go) begin
			case (ctl.cnt_op)
				olfb_pkg::CN_HOLD: cnt_q <= cnt_q;
				olfb_pkg::CN_INC:  cnt_q <= cnt_q + olfb_pkg::CNT_W'(1);
				olfb_pkg::CN_DEC:  cnt_q <= cnt_q - olfb_pkg::CNT_W'(1);
				default:           cnt_q <= cnt_q;
			endcase
			if (ctl.set_end) begin
				ended_q <= 1'b1;
			end
		end
	end

	// output register: loads whenever the slot is free or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && ctl.emit != olfb_pkg::EM_NONE) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			case (ctl.emit)
				olfb_pkg::EM_LIST: begin
					elem_q  <= rd_q;
					last_q  <= flags.last;
					empty_q <= 1'b0;
					ostat_q <= status_q;
				end
				olfb_pkg::EM_SINGLE: begin
					elem_q  <= '0;
					last_q  <= 1'b1;
					empty_q <= flags.empty;
					ostat_q <= status_q;
				end
				default: begin
					elem_q  <= elem_q;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = olfb_pkg::TDATA_W'(elem_q);
	assign m_tlast  = last_q;
	assign m_tuser  = {ostat_q, empty_q};

	`ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= olfb_pkg::CNT_W'(olfb_pkg::DEPTH))
	`ASSERT_NEVER(a_insert_full, clk, arst_n, go && (ctl.cnt_op == olfb_pkg::CN_INC) && flags.full)
	`ASSERT_ALWAYS(a_ended_sticky, clk, arst_n, ended_q |=> ended_q)

endmodule

// ===== tb/ordered_list_front_back_remove_tb.sv =====
// ---------------------------------------------------------------------------
// ordered_list_front_back_remove_tb
// Self-checking bench for the ordered list with front/back insert and remove.
// ---------------------------------------------------------------------------
// Commands go in on the slave stream. A scoreboard keeps its own copy of the
// list and, for every accepted command, queues the list words that the block
// must send back. Each output word is checked field by field against the
// oldest queued word. The run opens with hand-picked commands: not-found and
// most-negative removals, extreme values, duplicates and a full list. Random
// traffic follows, mostly removals of entries that are really there and
// inserts. A zero command and a few ignored commands close the run. Both
// sides stall at random in the opening and the first two of three phases;
// in the last, the output is held off once long enough to back up the input.
// ---------------------------------------------------------------------------
module ordered_list_front_back_remove_tb;
	import olfb_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_CMDS   = 228;
	localparam int DRAIN_CYCLES  = 40;
	localparam int MAX_REPORTS   = 20;

	// one expected output word
	typedef struct packed {
		logic [ELEM_W-1:0] element;
		logic              is_last;
		logic              list_empty;
		logic [STAT_W-1:0] status;
	} list_word_t;

	// Scoreboard: mirrors the list, predicts the words of each command and
	// checks the words that come back.
	class list_scoreboard;
		logic [ELEM_W-1:0] entries[$];
		bit                run_ended;
		list_word_t        pending_words[$];
		int                errors;
		int                cmds_seen;
		int                words_checked;
		int                status_hits[5];

		function void queue_word(logic [ELEM_W-1:0] elem, logic last, logic empty,
				logic [STAT_W-1:0] st);
			list_word_t w;
			w.element    = elem;
			w.is_last    = last;
			w.list_empty = empty;
			w.status     = st;
			pending_words.push_back(w);
		endfunction

		// apply one accepted command and queue the resulting words
		function void note_command(logic [VAL_W-1:0] cmd);
			logic [STAT_W-1:0] st;
			logic [VAL_W-1:0]  mag;
			bit                found;
			int                k;
			cmds_seen++;
			if (run_ended) begin
				status_hits[STS_IGNORED]++;
				queue_word('0, 1'b1, entries.size() == 0, STS_IGNORED);
				return;
			end
			if (cmd == '0) begin
				run_ended = 1'b1;
				st = STS_ENDED;
			end else if (cmd[VAL_W-1]) begin
				// magnitude of the most negative value has bit 31 set and
				// therefore never equals a stored entry
				mag = -cmd;
				found = 1'b0;
				for (k = 0; k < entries.size() && !found; k++) begin
					if ({1'b0, entries[k]} == mag) begin
						entries.delete(k);
						found = 1'b1;
					end
				end
				st = found ? STS_OK : STS_NOTFOUND;
			end else if (entries.size() >= DEPTH) begin
				st = STS_FULL;
			end else if (!cmd[0]) begin
				entries.push_front(cmd[ELEM_W-1:0]);
				st = STS_OK;
			end else begin
				entries.push_back(cmd[ELEM_W-1:0]);
				st = STS_OK;
			end
			status_hits[st]++;
			if (entries.size() == 0)
				queue_word('0, 1'b1, 1'b1, st);
			else
				for (k = 0; k < entries.size(); k++)
					queue_word(entries[k], k == entries.size() - 1, 1'b0, st);
		endfunction

		// compare one output word with the oldest expectation
		function void check_word(logic [TDATA_W-1:0] data, logic last,
				logic [TUSER_W-1:0] user);
			list_word_t want;
			list_word_t got;
			got.element    = data[ELEM_W-1:0];
			got.is_last    = last;
			got.list_empty = user[0];
			got.status     = user[TUSER_W-1:1];
			if (pending_words.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected word elem=%0d last=%b empty=%b status=%0d",
						$time, got.element, got.is_last, got.list_empty, got.status);
				return;
			end
			want = pending_words.pop_front();
			words_checked++;
			if (got != want || data[TDATA_W-1:ELEM_W] != '0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: mismatch expected elem=%0d last=%b empty=%b status=%0d, actual elem=%0d last=%b empty=%b status=%0d pad=%0h",
						$time, want.element, want.is_last, want.list_empty, want.status,
						got.element, got.is_last, got.list_empty, got.status,
						data[TDATA_W-1:ELEM_W]);
			end
		endfunction
	endclass

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [VAL_W-1:0]     s_tdata  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic                 m_tlast;
	logic [TUSER_W-1:0]   m_tuser;

	list_scoreboard sb = new();

	int tx_idle      = 0;   // percent of cycles the sender idles
	int rx_idle      = 0;   // percent of cycles the receiver stalls
	int hold_reqs    = 0;   // bumped by the stimulus to ask for a long stall
	int hold_served  = 0;
	int hold_left    = 0;
	int cycles       = 0;

	// hand-picked opening commands; the list is tracked in the comments
	logic [VAL_W-1:0] opening_cmds [12] = '{
		-32'sd5,                // remove on empty list: not found
		32'h8000_0000,          // most negative: never matches
		32'h7fff_fffe,          // largest even to front      [E]
		32'h7fff_ffff,          // largest odd to back        [E O]
		32'd1,                  //                            [E O 1]
		32'd2,                  //                            [2 E O 1]
		32'd6,                  //                            [6 2 E O 1]
		32'd6,                  // duplicate                  [6 6 2 E O 1]
		32'd3,                  //                            [6 6 2 E O 1 3]
		-32'sd6,                // first match only           [6 2 E O 1 3]
		-32'sd2147483647,       // remove largest odd         [6 2 E 1 3]
		-32'sd2147483646        // remove largest even        [6 2 1 3]
	};

	ordered_list_front_back_remove uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_reqs != hold_served) begin
			hold_served <= hold_reqs;
			hold_left   <= HOLD_CYCLES;
			m_tready    <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// Check every word taken on the output side.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata, m_tlast, m_tuser);
	end

	// Watchdog: give up long after the slowest correct run would finish.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected",
				cycles, sb.pending_words.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Offer one command word, idling first at the current rate, and hold it
	// until taken. Call right after a rising edge.
	task automatic send_command(input logic [VAL_W-1:0] cmd);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_command(cmd);
	endtask

	// Pick a random command other than zero. Most are removals of entries
	// that are really in the list, or inserts of small values so that
	// duplicates show up; the rest are wide values and missed removals.
	function automatic logic [VAL_W-1:0] pick_command();
		int               n;
		int               r;
		logic [VAL_W-1:0] cmd;
		n = sb.entries.size();
		r = $urandom_range(99);
		if (n > 0 && (r < 30 || (n >= 13 && r < 50))) begin
			cmd = -{1'b0, sb.entries[$urandom_range(n - 1)]};
		end else if (r < 40) begin
			if ($urandom_range(1))
				cmd = -$urandom_range(60, 1);
			else
				cmd = {1'b1, 31'($urandom)};
		end else if (r < 80) begin
			cmd = $urandom_range(60, 1);
		end else begin
			cmd = {1'b0, 31'($urandom)};
			if (cmd == '0)
				cmd = 32'd1;
		end
		return cmd;
	endfunction

	initial begin
		int k;
		int phase;
		tx_idle = 19;
		rx_idle = 53;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening
		for (k = 0; k < 12; k++)
			send_command(opening_cmds[k]);
		// fill to the brim, then try an insert at each end
		while (sb.entries.size() < DEPTH)
			send_command($urandom_range(60, 1));
		send_command(32'd100);
		send_command(32'd101);
		// remove the first entry equal to the one at the back of a full list
		send_command(-{1'b0, sb.entries[DEPTH-1]});

		// random traffic in three idle phases
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle = 19;
					rx_idle = 53;
				end
				1: begin
					tx_idle = 53;
					rx_idle = 19;
				end
				default: begin
					tx_idle = 0;
					rx_idle = 0;
				end
			endcase
			for (k = 0; k < RANDOM_CMDS / 3; k++) begin
				// back up the block once: output held, sender keeps offering
				if (phase == 2 && k == 10)
					hold_reqs++;
				send_command(pick_command());
			end
		end

		// end the run, then commands that must only be flagged
		send_command('0);
		send_command(32'd8);
		send_command(32'd9);
		send_command(-32'sd8);
		send_command(32'h8000_0000);
		s_tvalid <= 1'b0;

		while (sb.pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d commands, %0d list words checked", sb.cmds_seen, sb.words_checked);
		$display("status seen: ok %0d, not found %0d, full %0d, ended %0d, ignored %0d",
			sb.status_hits[STS_OK], sb.status_hits[STS_NOTFOUND],
			sb.status_hits[STS_FULL], sb.status_hits[STS_ENDED],
			sb.status_hits[STS_IGNORED]);
		if (sb.errors == 0 && sb.pending_words.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
